@@ rtl/core/vpcn_pkg.sv @@
// Shared types, codes and saturating helpers for the path command normalizer.
// Used by vpcn_in_stage, vpcn_exec and vector_path_command_normalizer_core.
package vpcn_pkg;

  localparam logic [3:0] OP_MOVE         = 4'd0;
  localparam logic [3:0] OP_LINE         = 4'd1;
  localparam logic [3:0] OP_HORIZ        = 4'd2;
  localparam logic [3:0] OP_VERT         = 4'd3;
  localparam logic [3:0] OP_QUAD         = 4'd4;
  localparam logic [3:0] OP_CUBIC        = 4'd5;
  localparam logic [3:0] OP_SMOOTH_QUAD  = 4'd6;
  localparam logic [3:0] OP_SMOOTH_CUBIC = 4'd7;
  localparam logic [3:0] OP_ARC          = 4'd8;
  localparam logic [3:0] OP_CLOSE        = 4'd9;

  localparam logic [2:0] KIND_MOVE  = 3'd0;
  localparam logic [2:0] KIND_LINE  = 3'd1;
  localparam logic [2:0] KIND_QUAD  = 3'd2;
  localparam logic [2:0] KIND_CUBIC = 3'd3;
  localparam logic [2:0] KIND_ARC   = 3'd4;
  localparam logic [2:0] KIND_CLOSE = 3'd5;
  localparam logic [2:0] KIND_ERROR = 3'd6;

  localparam logic [1:0] CLS_NONE  = 2'd0;
  localparam logic [1:0] CLS_QUAD  = 2'd1;
  localparam logic [1:0] CLS_CUBIC = 2'd2;

  localparam logic signed [31:0] COORD_MAX = 32'sh7FFF_FFFF;
  localparam logic signed [31:0] COORD_MIN = 32'sh8000_0000;

  typedef logic signed [31:0] coord_t;

  typedef struct packed {
    logic [3:0] op;
    logic       relative;
    coord_t     v0;
    coord_t     v1;
    coord_t     v2;
    coord_t     v3;
    coord_t     v4;
    coord_t     v5;
    logic       large_arc;
    logic       sweep;
  } item_t;

  typedef struct packed {
    logic [2:0] seg_kind;
    coord_t     p1_x;
    coord_t     p1_y;
    coord_t     p2_x;
    coord_t     p2_y;
    coord_t     p3_x;
    coord_t     p3_y;
    coord_t     from_x;
    coord_t     from_y;
    coord_t     arc_rotation;
    logic       large_arc;
    logic       sweep;
  } result_t;

  // Clamp a 33-bit sum back into Q16.16 range.
  function automatic coord_t sat33(input logic signed [32:0] s);
    coord_t r;
    if (s[32] != s[31]) begin
      r = s[32] ? COORD_MIN : COORD_MAX;
    end else begin
      r = s[31:0];
    end
    return r;
  endfunction

  // Operand, offset by the base point when relative.
  function automatic coord_t offs(input coord_t v, input coord_t base, input logic rel);
    logic signed [32:0] s;
    s = rel ? ({v[31], v} + {base[31], base}) : {v[31], v};
    return sat33(s);
  endfunction

  // Mirror k about c: 2c - k, saturated.
  function automatic coord_t reflect(input coord_t c, input coord_t k);
    logic signed [33:0] s;
    coord_t r;
    s = {c[31], c, 1'b0} - {{2{k[31]}}, k};
    if ((s[33] != s[32]) || (s[32] != s[31])) begin
      r = s[33] ? COORD_MIN : COORD_MAX;
    end else begin
      r = s[31:0];
    end
    return r;
  endfunction

endpackage

@@ rtl/core/vpcn_in_stage.sv @@
// Input register stage: captures one command transaction and holds it until
// the execute stage takes it. Depends on vpcn_pkg.
module vpcn_in_stage (
  input  logic            clk,
  input  logic            rst_n,
  input  logic            in_valid,
  output logic            in_stall,
  input  vpcn_pkg::item_t in_item,
  input  logic            advance,
  output logic            item_valid,
  output vpcn_pkg::item_t item
);

  logic            valid_r, valid_nxt;
  vpcn_pkg::item_t item_r;
  logic            accept;

  assign in_stall  = valid_r && !advance;
  assign accept    = in_valid && !in_stall;
  assign valid_nxt = accept || (valid_r && !advance);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else begin
      valid_r <= valid_nxt;
    end
    if (accept) begin
      item_r <= in_item;
    end
  end

  assign item_valid = valid_r;
  assign item       = item_r;

endmodule

@@ rtl/core/vpcn_exec.sv @@
// Execute stage: path state registers and the single-pass segment logic.
// Depends on vpcn_pkg.
module vpcn_exec (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              commit,
  input  vpcn_pkg::item_t   item,
  output vpcn_pkg::result_t result
);

  vpcn_pkg::coord_t cur_x_r, cur_y_r, start_x_r, start_y_r, ctrl_x_r, ctrl_y_r;
  vpcn_pkg::coord_t cur_x_nxt, cur_y_nxt, start_x_nxt, start_y_nxt;
  vpcn_pkg::coord_t ctrl_x_nxt, ctrl_y_nxt;
  logic [1:0]       prev_class_r, prev_class_nxt;
  logic             started_r, started_nxt, halted_r, halted_nxt;

  vpcn_pkg::coord_t ox0, oy1, ox2, oy3, ox4, oy5, oy0, ox3, oy4, rx, ry;
  logic             bad_op, err;

  always_comb begin
    ox0 = vpcn_pkg::offs(item.v0, cur_x_r, item.relative);
    oy1 = vpcn_pkg::offs(item.v1, cur_y_r, item.relative);
    ox2 = vpcn_pkg::offs(item.v2, cur_x_r, item.relative);
    oy3 = vpcn_pkg::offs(item.v3, cur_y_r, item.relative);
    ox4 = vpcn_pkg::offs(item.v4, cur_x_r, item.relative);
    oy5 = vpcn_pkg::offs(item.v5, cur_y_r, item.relative);
    oy0 = vpcn_pkg::offs(item.v0, cur_y_r, item.relative);
    ox3 = vpcn_pkg::offs(item.v3, cur_x_r, item.relative);
    oy4 = vpcn_pkg::offs(item.v4, cur_y_r, item.relative);
    rx  = vpcn_pkg::reflect(cur_x_r, ctrl_x_r);
    ry  = vpcn_pkg::reflect(cur_y_r, ctrl_y_r);
  end

  assign bad_op = item.op > vpcn_pkg::OP_CLOSE;
  assign err    = halted_r || bad_op || (!started_r && item.op != vpcn_pkg::OP_MOVE);

  always_comb begin
    result         = '0;
    cur_x_nxt      = cur_x_r;
    cur_y_nxt      = cur_y_r;
    start_x_nxt    = start_x_r;
    start_y_nxt    = start_y_r;
    ctrl_x_nxt     = ctrl_x_r;
    ctrl_y_nxt     = ctrl_y_r;
    prev_class_nxt = prev_class_r;
    started_nxt    = started_r;
    halted_nxt     = halted_r || bad_op;

    if (err) begin
      result.seg_kind = vpcn_pkg::KIND_ERROR;
    end else begin
      result.from_x  = cur_x_r;
      result.from_y  = cur_y_r;
      prev_class_nxt = vpcn_pkg::CLS_NONE;
      case (item.op)
        vpcn_pkg::OP_MOVE: begin
          result.seg_kind = vpcn_pkg::KIND_MOVE;
          result.p1_x     = ox0;
          result.p1_y     = oy1;
          start_x_nxt     = ox0;
          start_y_nxt     = oy1;
          started_nxt     = 1'b1;
        end
        vpcn_pkg::OP_LINE: begin
          result.seg_kind = vpcn_pkg::KIND_LINE;
          result.p1_x     = ox0;
          result.p1_y     = oy1;
        end
        vpcn_pkg::OP_HORIZ: begin
          result.seg_kind = vpcn_pkg::KIND_LINE;
          result.p1_x     = ox0;
          result.p1_y     = cur_y_r;
        end
        vpcn_pkg::OP_VERT: begin
          result.seg_kind = vpcn_pkg::KIND_LINE;
          result.p1_x     = cur_x_r;
          result.p1_y     = oy0;
        end
        vpcn_pkg::OP_QUAD: begin
          result.seg_kind = vpcn_pkg::KIND_QUAD;
          result.p1_x     = ox0;
          result.p1_y     = oy1;
          result.p2_x     = ox2;
          result.p2_y     = oy3;
          prev_class_nxt  = vpcn_pkg::CLS_QUAD;
        end
        vpcn_pkg::OP_SMOOTH_QUAD: begin
          result.seg_kind = vpcn_pkg::KIND_QUAD;
          result.p1_x     = (prev_class_r == vpcn_pkg::CLS_QUAD) ? rx : cur_x_r;
          result.p1_y     = (prev_class_r == vpcn_pkg::CLS_QUAD) ? ry : cur_y_r;
          result.p2_x     = ox0;
          result.p2_y     = oy1;
          prev_class_nxt  = vpcn_pkg::CLS_QUAD;
        end
        vpcn_pkg::OP_CUBIC: begin
          result.seg_kind = vpcn_pkg::KIND_CUBIC;
          result.p1_x     = ox0;
          result.p1_y     = oy1;
          result.p2_x     = ox2;
          result.p2_y     = oy3;
          result.p3_x     = ox4;
          result.p3_y     = oy5;
          prev_class_nxt  = vpcn_pkg::CLS_CUBIC;
        end
        vpcn_pkg::OP_SMOOTH_CUBIC: begin
          result.seg_kind = vpcn_pkg::KIND_CUBIC;
          result.p1_x     = (prev_class_r == vpcn_pkg::CLS_CUBIC) ? rx : cur_x_r;
          result.p1_y     = (prev_class_r == vpcn_pkg::CLS_CUBIC) ? ry : cur_y_r;
          result.p2_x     = ox0;
          result.p2_y     = oy1;
          result.p3_x     = ox2;
          result.p3_y     = oy3;
          prev_class_nxt  = vpcn_pkg::CLS_CUBIC;
        end
        vpcn_pkg::OP_ARC: begin
          result.seg_kind     = vpcn_pkg::KIND_ARC;
          result.p1_x         = item.v0;
          result.p1_y         = item.v1;
          result.arc_rotation = item.v2;
          result.p3_x         = ox3;
          result.p3_y         = oy4;
          result.large_arc    = item.large_arc;
          result.sweep        = item.sweep;
        end
        default: begin
          // close: return to the subpath start
          result.seg_kind = vpcn_pkg::KIND_CLOSE;
          result.p1_x     = start_x_r;
          result.p1_y     = start_y_r;
        end
      endcase

      // Track the end point and the last control point per segment kind.
      case (result.seg_kind)
        vpcn_pkg::KIND_QUAD: begin
          ctrl_x_nxt = result.p1_x;
          ctrl_y_nxt = result.p1_y;
          cur_x_nxt  = result.p2_x;
          cur_y_nxt  = result.p2_y;
        end
        vpcn_pkg::KIND_CUBIC: begin
          ctrl_x_nxt = result.p2_x;
          ctrl_y_nxt = result.p2_y;
          cur_x_nxt  = result.p3_x;
          cur_y_nxt  = result.p3_y;
        end
        vpcn_pkg::KIND_ARC: begin
          cur_x_nxt = result.p3_x;
          cur_y_nxt = result.p3_y;
        end
        default: begin
          cur_x_nxt = result.p1_x;
          cur_y_nxt = result.p1_y;
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cur_x_r      <= '0;
      cur_y_r      <= '0;
      start_x_r    <= '0;
      start_y_r    <= '0;
      ctrl_x_r     <= '0;
      ctrl_y_r     <= '0;
      prev_class_r <= vpcn_pkg::CLS_NONE;
      started_r    <= 1'b0;
      halted_r     <= 1'b0;
    end else if (commit) begin
      cur_x_r      <= cur_x_nxt;
      cur_y_r      <= cur_y_nxt;
      start_x_r    <= start_x_nxt;
      start_y_r    <= start_y_nxt;
      ctrl_x_r     <= ctrl_x_nxt;
      ctrl_y_r     <= ctrl_y_nxt;
      prev_class_r <= prev_class_nxt;
      started_r    <= started_nxt;
      halted_r     <= halted_nxt;
    end
  end

  a_halt_sticky: assert property (@(posedge clk) disable iff (!rst_n)
    halted_r |=> halted_r)
    else $error("halt flag cleared without reset");

  a_halt_freezes: assert property (@(posedge clk) disable iff (!rst_n)
    (commit && halted_r) |=> ($stable(cur_x_r) && $stable(cur_y_r) && $stable(ctrl_x_r)))
    else $error("path state moved while halted");

  a_started_sticky: assert property (@(posedge clk) disable iff (!rst_n)
    started_r |=> started_r)
    else $error("started flag cleared without reset");

  a_error_no_state: assert property (@(posedge clk) disable iff (!rst_n)
    (commit && !started_r && item.op != vpcn_pkg::OP_MOVE) |=>
      ($stable(cur_x_r) && $stable(start_x_r) && !started_r))
    else $error("command before first move changed the state");

endmodule

@@ rtl/core/vector_path_command_normalizer_core.sv @@
// Path command normalizer: one command transaction in, one absolute segment out.
// Path: the accepted command is held in the input reg, then its segment in the result reg.
// Throughput: one command per cycle while out_stall is low; the current point feeds back through the path state regs.
// Reset (rst_n low, synchronous) clears both stages, current point, subpath start,
// control point, curve class, started and the sticky halt.
// Depends on vpcn_pkg, vpcn_in_stage and vpcn_exec.
module vector_path_command_normalizer_core (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic [3:0]  in_op,
  input  logic        in_relative,
  input  logic [31:0] in_v0,
  input  logic [31:0] in_v1,
  input  logic [31:0] in_v2,
  input  logic [31:0] in_v3,
  input  logic [31:0] in_v4,
  input  logic [31:0] in_v5,
  input  logic        in_large_arc_in,
  input  logic        in_sweep_in,
  output logic        out_valid,
  input  logic        out_stall,
  output logic [2:0]  out_seg_kind,
  output logic [31:0] out_p1_x,
  output logic [31:0] out_p1_y,
  output logic [31:0] out_p2_x,
  output logic [31:0] out_p2_y,
  output logic [31:0] out_p3_x,
  output logic [31:0] out_p3_y,
  output logic [31:0] out_from_x,
  output logic [31:0] out_from_y,
  output logic [31:0] out_arc_rotation,
  output logic        out_large_arc_out,
  output logic        out_sweep_out
);

  vpcn_pkg::item_t   in_item, item;
  vpcn_pkg::result_t result, out_r;
  logic              item_valid, advance;
  logic              out_valid_r, out_valid_nxt;

  always_comb begin
    in_item.op        = in_op;
    in_item.relative  = in_relative;
    in_item.v0        = in_v0;
    in_item.v1        = in_v1;
    in_item.v2        = in_v2;
    in_item.v3        = in_v3;
    in_item.v4        = in_v4;
    in_item.v5        = in_v5;
    in_item.large_arc = in_large_arc_in;
    in_item.sweep     = in_sweep_in;
  end

  // advance the held command when the result register is free or draining
  assign advance       = item_valid && (!out_valid_r || !out_stall);
  assign out_valid_nxt = advance || (out_valid_r && out_stall);

  vpcn_in_stage u_in_stage (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_valid   (in_valid),
    .in_stall   (in_stall),
    .in_item    (in_item),
    .advance    (advance),
    .item_valid (item_valid),
    .item       (item)
  );

  vpcn_exec u_exec (
    .clk    (clk),
    .rst_n  (rst_n),
    .commit (advance),
    .item   (item),
    .result (result)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= out_valid_nxt;
    end
    if (advance) begin
      out_r <= result;
    end
  end

  assign out_valid         = out_valid_r;
  assign out_seg_kind      = out_r.seg_kind;
  assign out_p1_x          = out_r.p1_x;
  assign out_p1_y          = out_r.p1_y;
  assign out_p2_x          = out_r.p2_x;
  assign out_p2_y          = out_r.p2_y;
  assign out_p3_x          = out_r.p3_x;
  assign out_p3_y          = out_r.p3_y;
  assign out_from_x        = out_r.from_x;
  assign out_from_y        = out_r.from_y;
  assign out_arc_rotation  = out_r.arc_rotation;
  assign out_large_arc_out = out_r.large_arc;
  assign out_sweep_out     = out_r.sweep;

endmodule

@@ tb/tb.sv @@
// Testbench for vector_path_command_normalizer_core: directed and random path commands,
// each one predicted into an absolute segment and checked against the block's output.
// Depends on vpcn_pkg and the RTL of vector_path_command_normalizer_core.
module tb;
  import vpcn_pkg::*;

  localparam int     CYCLE_LIMIT  = 1_000_000;
  localparam int     DRAIN_CYCLES = 8;
  localparam int     RANDOM_CMDS  = 1516;
  localparam coord_t UNIT         = 32'sh0001_0000;

  logic clk;
  logic rst_n = 1'b0;

  logic        in_valid  = 1'b0;
  logic        in_stall;
  logic        out_valid;
  logic        out_stall = 1'b0;
  logic [2:0]  out_seg_kind;
  logic [31:0] out_p1_x, out_p1_y, out_p2_x, out_p2_y, out_p3_x, out_p3_y;
  logic [31:0] out_from_x, out_from_y, out_arc_rotation;
  logic        out_large_arc_out, out_sweep_out;

  item_t   cur_cmd = '0;
  item_t   pending_cmds[$];
  result_t expected_segs[$];

  int cmds_sent   = 0;
  int cmds_taken  = 0;
  int total_cmds  = 0;
  int mismatches  = 0;
  int cycle_count = 0;
  int gap_left    = 0;
  int in_calm     = 0;
  int stall_left  = 0;
  int out_calm    = 0;
  int hold_left   = 0;
  int hold_at     = 400;

  // Predictor state
  coord_t     pen_x = '0, pen_y = '0;
  coord_t     sub_x = '0, sub_y = '0;
  coord_t     ctl_x = '0, ctl_y = '0;
  logic [1:0] curve_cls   = CLS_NONE;
  logic       path_open   = 1'b0;
  logic       path_halted = 1'b0;

  vector_path_command_normalizer_core u_top (
    .clk               (clk),
    .rst_n             (rst_n),
    .in_valid          (in_valid),
    .in_stall          (in_stall),
    .in_op             (cur_cmd.op),
    .in_relative       (cur_cmd.relative),
    .in_v0             (cur_cmd.v0),
    .in_v1             (cur_cmd.v1),
    .in_v2             (cur_cmd.v2),
    .in_v3             (cur_cmd.v3),
    .in_v4             (cur_cmd.v4),
    .in_v5             (cur_cmd.v5),
    .in_large_arc_in   (cur_cmd.large_arc),
    .in_sweep_in       (cur_cmd.sweep),
    .out_valid         (out_valid),
    .out_stall         (out_stall),
    .out_seg_kind      (out_seg_kind),
    .out_p1_x          (out_p1_x),
    .out_p1_y          (out_p1_y),
    .out_p2_x          (out_p2_x),
    .out_p2_y          (out_p2_y),
    .out_p3_x          (out_p3_x),
    .out_p3_y          (out_p3_y),
    .out_from_x        (out_from_x),
    .out_from_y        (out_from_y),
    .out_arc_rotation  (out_arc_rotation),
    .out_large_arc_out (out_large_arc_out),
    .out_sweep_out     (out_sweep_out)
  );

  function automatic coord_t clamp_coord(input longint s);
    if (s > longint'(COORD_MAX)) return COORD_MAX;
    if (s < longint'(COORD_MIN)) return COORD_MIN;
    return coord_t'(s);
  endfunction

  function automatic coord_t shift_pt(input coord_t v, input coord_t base, input logic rel);
    return rel ? clamp_coord(longint'(v) + longint'(base)) : v;
  endfunction

  function automatic coord_t mirror(input coord_t c, input coord_t k);
    return clamp_coord(2 * longint'(c) - longint'(k));
  endfunction

  // Turn one command into its absolute segment and advance the pen state.
  function automatic result_t normalize_cmd(input item_t c);
    result_t r;
    logic    rel;
    r   = '0;
    rel = c.relative;
    if (c.op > OP_CLOSE) path_halted = 1'b1;
    if (path_halted || (!path_open && c.op != OP_MOVE)) begin
      r.seg_kind = KIND_ERROR;
      return r;
    end
    r.from_x = pen_x;
    r.from_y = pen_y;
    case (c.op)
      OP_MOVE: begin
        r.seg_kind = KIND_MOVE;
        r.p1_x = shift_pt(c.v0, pen_x, rel);
        r.p1_y = shift_pt(c.v1, pen_y, rel);
        sub_x = r.p1_x;
        sub_y = r.p1_y;
        path_open = 1'b1;
      end
      OP_LINE, OP_HORIZ, OP_VERT: begin
        r.seg_kind = KIND_LINE;
        r.p1_x = (c.op == OP_VERT) ? pen_x : shift_pt(c.v0, pen_x, rel);
        if (c.op == OP_LINE) r.p1_y = shift_pt(c.v1, pen_y, rel);
        else if (c.op == OP_VERT) r.p1_y = shift_pt(c.v0, pen_y, rel);
        else r.p1_y = pen_y;
      end
      OP_QUAD, OP_SMOOTH_QUAD: begin
        r.seg_kind = KIND_QUAD;
        if (c.op == OP_QUAD) begin
          r.p1_x = shift_pt(c.v0, pen_x, rel);
          r.p1_y = shift_pt(c.v1, pen_y, rel);
          r.p2_x = shift_pt(c.v2, pen_x, rel);
          r.p2_y = shift_pt(c.v3, pen_y, rel);
        end else begin
          r.p1_x = (curve_cls == CLS_QUAD) ? mirror(pen_x, ctl_x) : pen_x;
          r.p1_y = (curve_cls == CLS_QUAD) ? mirror(pen_y, ctl_y) : pen_y;
          r.p2_x = shift_pt(c.v0, pen_x, rel);
          r.p2_y = shift_pt(c.v1, pen_y, rel);
        end
        ctl_x = r.p1_x;
        ctl_y = r.p1_y;
      end
      OP_CUBIC, OP_SMOOTH_CUBIC: begin
        r.seg_kind = KIND_CUBIC;
        if (c.op == OP_CUBIC) begin
          r.p1_x = shift_pt(c.v0, pen_x, rel);
          r.p1_y = shift_pt(c.v1, pen_y, rel);
          r.p2_x = shift_pt(c.v2, pen_x, rel);
          r.p2_y = shift_pt(c.v3, pen_y, rel);
          r.p3_x = shift_pt(c.v4, pen_x, rel);
          r.p3_y = shift_pt(c.v5, pen_y, rel);
        end else begin
          r.p1_x = (curve_cls == CLS_CUBIC) ? mirror(pen_x, ctl_x) : pen_x;
          r.p1_y = (curve_cls == CLS_CUBIC) ? mirror(pen_y, ctl_y) : pen_y;
          r.p2_x = shift_pt(c.v0, pen_x, rel);
          r.p2_y = shift_pt(c.v1, pen_y, rel);
          r.p3_x = shift_pt(c.v2, pen_x, rel);
          r.p3_y = shift_pt(c.v3, pen_y, rel);
        end
        ctl_x = r.p2_x;
        ctl_y = r.p2_y;
      end
      OP_ARC: begin
        // Radii and rotation pass through untouched, even when relative.
        r.seg_kind     = KIND_ARC;
        r.p1_x         = c.v0;
        r.p1_y         = c.v1;
        r.arc_rotation = c.v2;
        r.p3_x         = shift_pt(c.v3, pen_x, rel);
        r.p3_y         = shift_pt(c.v4, pen_y, rel);
        r.large_arc    = c.large_arc;
        r.sweep        = c.sweep;
      end
      default: begin
        r.seg_kind = KIND_CLOSE;
        r.p1_x = sub_x;
        r.p1_y = sub_y;
      end
    endcase
    case (r.seg_kind)
      KIND_QUAD: begin
        pen_x = r.p2_x;
        pen_y = r.p2_y;
        curve_cls = CLS_QUAD;
      end
      KIND_CUBIC, KIND_ARC: begin
        pen_x = r.p3_x;
        pen_y = r.p3_y;
        curve_cls = (r.seg_kind == KIND_CUBIC) ? CLS_CUBIC : CLS_NONE;
      end
      default: begin
        pen_x = r.p1_x;
        pen_y = r.p1_y;
        curve_cls = CLS_NONE;
      end
    endcase
    return r;
  endfunction

  // Mostly small offsets, with limits, near-limit and full-range values mixed in.
  function automatic coord_t rand_coord();
    case ($urandom_range(0, 15))
      0:       return COORD_MAX;
      1:       return COORD_MIN;
      2:       return '0;
      3, 4:    return $urandom;
      5:       return COORD_MAX - coord_t'($urandom_range(0, 32'h0002_0000));
      6:       return COORD_MIN + coord_t'($urandom_range(0, 32'h0002_0000));
      default: return coord_t'(int'($urandom_range(0, 32'h00FF_FFFF)) - 32'sh0080_0000);
    endcase
  endfunction

  // Idle length: mostly none, some short, a few long, with calm stretches.
  function automatic int idle_len(inout int calm);
    int r;
    if (calm > 0) begin
      calm--;
      return 0;
    end
    r = $urandom_range(0, 99);
    if (r < 2) begin
      calm = $urandom_range(30, 120);
      return 0;
    end
    if (r < 65) return 0;
    if (r < 93) return $urandom_range(1, 3);
    return $urandom_range(8, 30);
  endfunction

  task automatic push_cmd(input logic [3:0] op, input logic rel,
                          input coord_t a, input coord_t b, input coord_t c,
                          input coord_t d, input coord_t e, input coord_t f,
                          input logic la, input logic sw);
    item_t it;
    it.op        = op;
    it.relative  = rel;
    it.v0        = a;
    it.v1        = b;
    it.v2        = c;
    it.v3        = d;
    it.v4        = e;
    it.v5        = f;
    it.large_arc = la;
    it.sweep     = sw;
    pending_cmds = {pending_cmds, it};
  endtask

  task automatic push_random(input logic [3:0] op);
    push_cmd(op, 1'($urandom_range(0, 1)), rand_coord(), rand_coord(), rand_coord(),
             rand_coord(), rand_coord(), rand_coord(),
             1'($urandom_range(0, 1)), 1'($urandom_range(0, 1)));
  endtask

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("vector_path_command_normalizer_core test failed");
      $finish;
    end
  end

  // Take a transaction and record the segment it must produce.
  always @(posedge clk) begin : cmd_accept
    if (rst_n && in_valid && !in_stall) begin
      expected_segs = {expected_segs, normalize_cmd(cur_cmd)};
      cmds_taken++;
    end
  end

  always @(negedge clk) begin : cmd_drive
    if (!rst_n) begin
      in_valid <= 1'b0;
    end else if (!in_valid || cmds_taken == cmds_sent) begin
      if (gap_left > 0) begin
        gap_left--;
        in_valid <= 1'b0;
      end else if (pending_cmds.size() != 0) begin
        cur_cmd = pending_cmds.pop_front();
        cmds_sent++;
        in_valid <= 1'b1;
        gap_left = idle_len(in_calm);
      end else begin
        in_valid <= 1'b0;
      end
    end
  end

  // Random stalls, plus long hold-offs that back the block up into its input.
  always @(negedge clk) begin : seg_stall
    if (hold_left > 0) begin
      hold_left--;
      out_stall <= 1'b1;
    end else if (cmds_taken >= hold_at) begin
      hold_at += 700;
      hold_left = 80;
      out_stall <= 1'b1;
    end else if (stall_left > 0) begin
      stall_left--;
      out_stall <= 1'b1;
    end else begin
      out_stall <= 1'b0;
      stall_left = idle_len(out_calm);
    end
  end

  task automatic check_field(input string name, input logic [31:0] want,
                             input logic [31:0] got);
    if (want !== got) begin
      $display("%0t: %s mismatch, expected %h, actual %h", $time, name, want, got);
      mismatches++;
    end
  endtask

  always @(posedge clk) begin : seg_monitor
    result_t want;
    if (rst_n && out_valid && !out_stall) begin
      if (expected_segs.size() == 0) begin
        $display("%0t: unexpected segment, kind %0d, expected none", $time, out_seg_kind);
        mismatches++;
      end else begin
        want = expected_segs.pop_front();
        check_field("seg_kind", 32'(want.seg_kind), 32'(out_seg_kind));
        check_field("p1_x", want.p1_x, out_p1_x);
        check_field("p1_y", want.p1_y, out_p1_y);
        check_field("p2_x", want.p2_x, out_p2_x);
        check_field("p2_y", want.p2_y, out_p2_y);
        check_field("p3_x", want.p3_x, out_p3_x);
        check_field("p3_y", want.p3_y, out_p3_y);
        check_field("from_x", want.from_x, out_from_x);
        check_field("from_y", want.from_y, out_from_y);
        check_field("arc_rotation", want.arc_rotation, out_arc_rotation);
        check_field("large_arc", 32'(want.large_arc), 32'(out_large_arc_out));
        check_field("sweep", 32'(want.sweep), 32'(out_sweep_out));
      end
    end
  end

  initial begin : stimulus
    logic [3:0] op;
    logic [3:0] last_op;
    int         run_left;
    int         r;

    // Commands before the first move are rejected without halting.
    push_cmd(OP_LINE, 1'b0, UNIT, 2 * UNIT, 0, 0, 0, 0, 1'b0, 1'b0);
    push_cmd(OP_CLOSE, 1'b1, 0, 0, 0, 0, 0, 0, 1'b0, 1'b0);
    push_cmd(OP_SMOOTH_CUBIC, 1'b0, UNIT, UNIT, UNIT, UNIT, 0, 0, 1'b0, 1'b0);
    push_cmd(OP_MOVE, 1'b1, 3 * UNIT, -4 * UNIT, 0, 0, 0, 0, 1'b0, 1'b0);
    push_cmd(OP_LINE, 1'b0, COORD_MAX, COORD_MIN, 0, 0, 0, 0, 1'b0, 1'b0);
    push_cmd(OP_LINE, 1'b1, COORD_MAX, COORD_MIN, 0, 0, 0, 0, 1'b0, 1'b0);
    push_cmd(OP_HORIZ, 1'b1, COORD_MIN, UNIT, 0, 0, 0, 0, 1'b0, 1'b0);
    push_cmd(OP_VERT, 1'b0, 5 * UNIT, UNIT, 0, 0, 0, 0, 1'b0, 1'b0);
    // Reflection that saturates in both axes.
    push_cmd(OP_QUAD, 1'b0, COORD_MIN, COORD_MAX, COORD_MAX, COORD_MIN, 0, 0, 1'b0, 1'b0);
    push_cmd(OP_SMOOTH_QUAD, 1'b1, UNIT, UNIT, 0, 0, 0, 0, 1'b0, 1'b0);
    push_cmd(OP_SMOOTH_CUBIC, 1'b0, 7 * UNIT, 8 * UNIT, 9 * UNIT, -UNIT, 0, 0, 1'b0, 1'b0);
    push_cmd(OP_SMOOTH_CUBIC, 1'b1, UNIT, -2 * UNIT, 3 * UNIT, UNIT, 0, 0, 1'b0, 1'b0);
    push_cmd(OP_CUBIC, 1'b1, -UNIT, UNIT, 2 * UNIT, -3 * UNIT, 4 * UNIT, 5 * UNIT,
             1'b0, 1'b0);
    push_cmd(OP_SMOOTH_QUAD, 1'b0, -6 * UNIT, 2 * UNIT, 0, 0, 0, 0, 1'b0, 1'b0);
    push_cmd(OP_ARC, 1'b1, -2 * UNIT, 3 * UNIT, COORD_MIN, UNIT, -UNIT, 32'sh1234_5678,
             1'b1, 1'b0);
    push_cmd(OP_ARC, 1'b0, COORD_MAX, COORD_MIN, COORD_MAX, COORD_MIN, COORD_MAX, -1,
             1'b0, 1'b1);
    push_cmd(OP_CLOSE, 1'b1, $urandom, $urandom, $urandom, $urandom, $urandom, $urandom,
             1'b1, 1'b1);
    push_cmd(OP_MOVE, 1'b0, COORD_MIN, COORD_MAX, 0, 0, 0, 0, 1'b0, 1'b0);
    push_cmd(OP_MOVE, 1'b1, -1, 1, 0, 0, 0, 0, 1'b0, 1'b0);
    push_cmd(OP_CLOSE, 1'b0, 0, 0, 0, 0, 0, 0, 1'b0, 1'b0);
    push_cmd(OP_SMOOTH_QUAD, 1'b0, UNIT, UNIT, 0, 0, 0, 0, 1'b0, 1'b0);
    push_cmd(OP_SMOOTH_QUAD, 1'b1, -UNIT, 2 * UNIT, 0, 0, 0, 0, 1'b0, 1'b0);

    // Subpaths: a move, then a run of commands; smooth follow-ups are favored.
    last_op  = OP_MOVE;
    run_left = 0;
    repeat (RANDOM_CMDS) begin
      r = $urandom_range(0, 99);
      if (run_left == 0) begin
        op = OP_MOVE;
        run_left = $urandom_range(3, 30);
      end else if ((last_op == OP_QUAD || last_op == OP_SMOOTH_QUAD) && r < 40) begin
        op = OP_SMOOTH_QUAD;
      end else if ((last_op == OP_CUBIC || last_op == OP_SMOOTH_CUBIC) && r < 40) begin
        op = OP_SMOOTH_CUBIC;
      end else begin
        op = 4'($urandom_range(0, 9));
      end
      if (run_left > 0) run_left--;
      push_random(op);
      last_op = op;
    end

    // Unknown commands halt the block for good, so they come last.
    for (int k = OP_CLOSE + 1; k <= 15; k++) push_random(4'(k));
    repeat (6) push_random(4'($urandom_range(0, 9)));
    total_cmds = pending_cmds.size();

    repeat (12) @(posedge clk);
    @(negedge clk);
    rst_n = 1'b1;

    while (cmds_taken < total_cmds) @(posedge clk);
    while (expected_segs.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (mismatches == 0) begin
      $display("vector_path_command_normalizer_core test passed");
    end else begin
      $display("vector_path_command_normalizer_core test failed");
    end
    $finish;
  end

endmodule
